### sv/twdr_pkg.sv
`default_nettype none
package twdr_pkg;
    localparam int WORD_BITS = 64;
    localparam int DIV_STEPS = 2 * WORD_BITS;
    localparam int HALF_BITS = WORD_BITS / 2;
    typedef logic [WORD_BITS-1:0] t_word;

    // Data carried from one division cell to the next.
    typedef struct packed {
        logic  vld;
        t_word num_hi;  // bits of the dividend not yet shifted in
        t_word num_lo;
        t_word dsr;     // divisor word d1 + 1
        t_word quo;
        t_word rem;
        t_word d1;
        t_word d2;
    } t_cell;
endpackage
`default_nettype wire

### sv/twdr_if.sv
`default_nettype none
interface twdr_in_if;
    logic             valid;
    logic             ready;
    twdr_pkg::t_word  divisor_high;
    twdr_pkg::t_word  divisor_low;
    modport source (output valid, divisor_high, divisor_low, input ready);
    modport sink (input valid, divisor_high, divisor_low, output ready);
endinterface

interface twdr_out_if;
    logic             valid;
    logic             ready;
    twdr_pkg::t_word  reciprocal;
    modport source (output valid, reciprocal, input ready);
    modport sink (input valid, reciprocal, output ready);
endinterface
`default_nettype wire

### sv/twdr_cell.sv
`default_nettype none
// One restoring division step: shift one dividend bit into the remainder,
// subtract the divisor when it fits.
module twdr_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  twdr_pkg::t_cell i_cell,
    output twdr_pkg::t_cell o_cell
);
    twdr_pkg::t_cell r_cell;
    twdr_pkg::t_cell n_cell;
    logic [twdr_pkg::WORD_BITS:0] w_sh;

    always_comb begin
        n_cell = i_cell;
        w_sh = {i_cell.rem, i_cell.num_hi[twdr_pkg::WORD_BITS-1]};
        n_cell.num_hi = {i_cell.num_hi[twdr_pkg::WORD_BITS-2:0],
                         i_cell.num_lo[twdr_pkg::WORD_BITS-1]};
        n_cell.num_lo = {i_cell.num_lo[twdr_pkg::WORD_BITS-2:0], 1'b0};
        if (w_sh >= {1'b0, i_cell.dsr}) begin
            n_cell.rem = twdr_pkg::WORD_BITS'(w_sh - {1'b0, i_cell.dsr});
            n_cell.quo = {i_cell.quo[twdr_pkg::WORD_BITS-2:0], 1'b1};
        end else begin
            n_cell.rem = w_sh[twdr_pkg::WORD_BITS-1:0];
            n_cell.quo = {i_cell.quo[twdr_pkg::WORD_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= i_cell.vld;
        end
        if (i_en) begin
            r_cell.num_hi <= n_cell.num_hi;
            r_cell.num_lo <= n_cell.num_lo;
            r_cell.dsr    <= n_cell.dsr;
            r_cell.quo    <= n_cell.quo;
            r_cell.rem    <= n_cell.rem;
            r_cell.d1     <= n_cell.d1;
            r_cell.d2     <= n_cell.d2;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

### sv/twdr_fix.sv
`default_nettype none
// Multiply-add and final quotient correction, four register stages.
module twdr_fix (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  twdr_pkg::t_cell i_cell,
    output logic            o_vld,
    output twdr_pkg::t_word o_recip
);
    localparam int W = twdr_pkg::WORD_BITS;
    localparam int H = twdr_pkg::HALF_BITS;
    localparam int L = W - H;

    logic [3:0] r_vld;
    // Stage 1: partial products.
    logic [2*H-1:0] r_p11;
    logic [H+L-1:0] r_p10, r_p01;
    logic [2*L-1:0] r_p00;
    twdr_pkg::t_word r1_q, r1_r, r1_d1, r1_d2;
    logic r1_both, r1_lo;
    // Stage 2: product.
    logic [2*W-1:0] r_prod;
    twdr_pkg::t_word r2_q, r2_r, r2_d1, r2_d2;
    logic r2_both, r2_lo;
    // Stage 3: sum.
    logic [W:0] r_s1;
    twdr_pkg::t_word r3_r0, r3_q, r3_c1, r3_c0;
    logic r3_both;
    twdr_pkg::t_word r_out;

    twdr_pkg::t_word w_q, w_r, w_m;
    logic w_both, w_hi, w_lo;
    logic [W-1:0] w_ones;

    always_comb begin
        w_ones = '1;
        w_hi   = (i_cell.d1 == w_ones);
        w_lo   = (i_cell.d2 == w_ones);
        w_both = w_hi && w_lo;
        w_q    = w_hi ? '0 : i_cell.quo;
        w_r    = w_hi ? ~i_cell.d2 : i_cell.rem;
        w_m    = ~i_cell.d2 - W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_cell.vld};
        end
        if (i_en) begin
            r_p00 <= w_q[L-1:0] * w_m[L-1:0];
            r_p01 <= w_q[L-1:0] * w_m[W-1:L];
            r_p10 <= w_q[W-1:L] * w_m[L-1:0];
            r_p11 <= w_q[W-1:L] * w_m[W-1:L];
            r1_q <= w_q; r1_r <= w_r; r1_d1 <= i_cell.d1; r1_d2 <= i_cell.d2;
            r1_both <= w_both; r1_lo <= w_lo;

            r_prod <= (2*W)'(r_p00) + ((2*W)'(r_p01) << L) + ((2*W)'(r_p10) << L)
                      + ((2*W)'(r_p11) << (2*L));
            r2_q <= r1_q; r2_r <= r1_r; r2_d1 <= r1_d1; r2_d2 <= r1_d2;
            r2_both <= r1_both; r2_lo <= r1_lo;

            if (r2_lo) begin
                r_s1  <= {1'b0, r2_r} + {1'b0, r2_q};
                r3_r0 <= '0;
                r3_c1 <= r2_d1 + W'(1);
            end else begin
                r_s1  <= {1'b0, r2_r} + {1'b0, r_prod[2*W-1:W]};
                r3_r0 <= r_prod[W-1:0];
                r3_c1 <= r2_d1;
            end
            r3_c0 <= r2_d2 + W'(1);
            r3_q <= r2_q; r3_both <= r2_both;

            if (r3_both) begin
                r_out <= '0;
            end else if (r_s1[W] || r_s1[W-1:0] > r3_c1
                         || (r_s1[W-1:0] == r3_c1 && r3_r0 >= r3_c0)) begin
                r_out <= r3_q + W'(1);
            end else begin
                r_out <= r3_q;
            end
        end
    end

    assign o_vld   = r_vld[3];
    assign o_recip = r_out;
endmodule
`default_nettype wire

### sv/two_word_divisor_reciprocal_unit.sv
`default_nettype none
// Two-word divisor reciprocal unit. Each input beat carries a divisor
// (divisor_high, divisor_low) and yields one output beat holding the one-word
// reciprocal used for three-by-two word division. The block is fully
// pipelined and accepts one beat per cycle while not stalled; a beat passes
// through the chain of restoring division cells (one quotient bit per cell)
// and then the multiply, add and correction stages.
// The whole pipeline advances together and halts only when the output
// register holds an untaken beat, so input ready follows output ready or an
// empty output register.
module two_word_divisor_reciprocal_unit (
    input wire i_clk,
    input wire i_rst_n,
    twdr_in_if.sink    i_in,
    twdr_out_if.source o_out
);
    localparam int N = twdr_pkg::DIV_STEPS;

    twdr_pkg::t_cell w_chain [0:N];
    logic w_en;
    logic w_vld;
    twdr_pkg::t_word w_recip;

    // The pipeline moves when the output stage is empty or being drained.
    assign w_en = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    always_comb begin
        w_chain[0].vld    = i_in.valid;
        w_chain[0].num_hi = ~i_in.divisor_high;
        w_chain[0].num_lo = ~i_in.divisor_low;
        // An all-ones high word wraps to zero here; that case bypasses q.
        w_chain[0].dsr    = i_in.divisor_high + twdr_pkg::WORD_BITS'(1);
        w_chain[0].quo    = '0;
        w_chain[0].rem    = '0;
        w_chain[0].d1     = i_in.divisor_high;
        w_chain[0].d2     = i_in.divisor_low;
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        twdr_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_cell (w_chain[g]),
            .o_cell (w_chain[g+1])
        );
    end

    twdr_fix u_fix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_cell (w_chain[N]),
        .o_vld  (w_vld),
        .o_recip(w_recip)
    );

    assign o_out.valid      = w_vld;
    assign o_out.reciprocal = w_recip;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.reciprocal))
        else $error("output beat changed while stalled");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && u_fix.r_vld[2] && u_fix.r3_both |=> (o_out.reciprocal == '0))
        else $error("all-ones divisor gave nonzero reciprocal");
endmodule
`default_nettype wire
